[rtl/core/dbt_pkg.sv]
// Shared types, constants and codes of the dirty band tracker.
// Used by every module of the block but dbt_ram; depends on nothing else.
`default_nettype none
package dbt_pkg;

   localparam int unsigned DIM_W       = 12;   // pixel coordinates and sizes
   localparam int unsigned COORD_W     = 16;   // Q.4 corner coordinates
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned IDX_W       = 6;    // band index field
   localparam int unsigned FRAC_BITS   = 4;
   localparam int unsigned MAX_CORNERS = 4;
   localparam int unsigned BANDS_DEF   = 16;
   localparam int unsigned QUEUE_DEF   = 2;
   localparam int unsigned CSR_IDX_W   = 1;

   // Box padding in Q.4 units: 3 pixels on the low sides, 4 on the high sides.
   localparam int PAD_LOW_Q  = 3 * (2 ** FRAC_BITS);
   localparam int PAD_HIGH_Q = 4 * (2 ** FRAC_BITS);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(480);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_INCLUDE = 2'd1,
      MODE_READ    = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type                   mode;
      logic [COUNT_W-1:0]         corner_count;
      logic signed [COORD_W-1:0]  corner_x0;
      logic signed [COORD_W-1:0]  corner_y0;
      logic signed [COORD_W-1:0]  corner_x1;
      logic signed [COORD_W-1:0]  corner_y1;
      logic signed [COORD_W-1:0]  corner_x2;
      logic signed [COORD_W-1:0]  corner_y2;
      logic signed [COORD_W-1:0]  corner_x3;
      logic signed [COORD_W-1:0]  corner_y3;
      logic [IDX_W-1:0]           band_index;
   } req_type;

   typedef struct packed {
      logic [DIM_W-1:0] rect_left;
      logic [DIM_W-1:0] rect_top;
      logic [DIM_W-1:0] rect_width;
      logic [DIM_W-1:0] rect_height;
   } rsp_type;

   // Classified command passed from the front to the back through the queue.
   typedef struct packed {
      mode_type         op;
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] right;
      logic [DIM_W-1:0] top;
      logic [DIM_W-1:0] bottom;
      logic [IDX_W-1:0] band_index;
   } cmd_type;

   // One band's stored span.
   typedef struct packed {
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] right;
   } span_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_READ,
      BK_REPLY
   } back_state_type;

endpackage
`default_nettype wire

[rtl/core/dbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the band span store.
`default_nettype none
module dbt_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/core/dbt_front.sv]
// Front of the dirty band tracker: accepts requests, forms the padded,
// clamped bounding box and queues classified commands. Uses dbt_pkg.
`default_nettype none
module dbt_front
   import dbt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   input  wire logic [DIM_W-1:0] display_width,
   input  wire logic [DIM_W-1:0] display_height,
   output logic                  q_push,
   output cmd_type               q_entry,
   input  wire logic             q_full
);

   localparam int unsigned Q_W = COORD_W + 2;

   function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Offset Q.4 value to whole pixels, floored at zero and limited to the display.
   function automatic logic [DIM_W-1:0] to_pixel(input logic signed [Q_W-1:0] q,
                                                 input logic [DIM_W-1:0] limit);
      logic [Q_W-FRAC_BITS-1:0] p;
      p = q[Q_W-1:FRAC_BITS];
      if (q <= 0) begin
         return '0;
      end
      return (p > (Q_W-FRAC_BITS)'(limit)) ? limit : p[DIM_W-1:0];
   endfunction

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_keep_ff,  s1_keep_in;
   mode_type                  s1_op_ff,    s1_op_in;
   logic [IDX_W-1:0]          s1_idx_ff,   s1_idx_in;
   logic signed [COORD_W-1:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [COORD_W-1:0] minx_in, maxx_in, miny_in, maxy_in;

   logic [COUNT_W-1:0]        n_eff;
   logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3;
   logic                      accept, s1_done, box_ok, need_push;
   logic [DIM_W-1:0]          px_left, px_right, px_top, px_bottom;

   // Corners beyond the count are replaced by the first one, which leaves the box unchanged.
   always_comb begin
      n_eff = (req_data.corner_count > COUNT_W'(MAX_CORNERS)) ?
              COUNT_W'(MAX_CORNERS) : req_data.corner_count;
      x1 = (n_eff > COUNT_W'(1)) ? req_data.corner_x1 : req_data.corner_x0;
      y1 = (n_eff > COUNT_W'(1)) ? req_data.corner_y1 : req_data.corner_y0;
      x2 = (n_eff > COUNT_W'(2)) ? req_data.corner_x2 : req_data.corner_x0;
      y2 = (n_eff > COUNT_W'(2)) ? req_data.corner_y2 : req_data.corner_y0;
      x3 = (n_eff > COUNT_W'(3)) ? req_data.corner_x3 : req_data.corner_x0;
      y3 = (n_eff > COUNT_W'(3)) ? req_data.corner_y3 : req_data.corner_y0;
   end

   always_comb begin
      px_left   = to_pixel(Q_W'(minx_ff) - Q_W'(PAD_LOW_Q), display_width);
      px_right  = to_pixel(Q_W'(maxx_ff) + Q_W'(PAD_HIGH_Q), display_width);
      px_top    = to_pixel(Q_W'(miny_ff) - Q_W'(PAD_LOW_Q), display_height);
      px_bottom = to_pixel(Q_W'(maxy_ff) + Q_W'(PAD_HIGH_Q), display_height);
      box_ok    = (px_right > px_left) && (px_bottom > px_top);
      need_push = s1_valid_ff && s1_keep_ff && ((s1_op_ff != MODE_INCLUDE) || box_ok);
      s1_done   = !need_push || !q_full;
      req_stall = s1_valid_ff && !s1_done;
      accept    = req_valid && !req_stall;
      q_push    = need_push && !q_full;

      q_entry.op         = s1_op_ff;
      q_entry.left       = px_left;
      q_entry.right      = px_right;
      q_entry.top        = px_top;
      q_entry.bottom     = px_bottom;
      q_entry.band_index = s1_idx_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_done;
      s1_keep_in  = s1_keep_ff;
      s1_op_in    = s1_op_ff;
      s1_idx_in   = s1_idx_ff;
      minx_in     = minx_ff;
      maxx_in     = maxx_ff;
      miny_in     = miny_ff;
      maxy_in     = maxy_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_data.mode;
         s1_idx_in   = req_data.band_index;
         minx_in     = smin(smin(req_data.corner_x0, x1), smin(x2, x3));
         maxx_in     = smax(smax(req_data.corner_x0, x1), smax(x2, x3));
         miny_in     = smin(smin(req_data.corner_y0, y1), smin(y2, y3));
         maxy_in     = smax(smax(req_data.corner_y0, y1), smax(y2, y3));
         case (req_data.mode) inside
            MODE_CLEAR, MODE_READ: s1_keep_in = 1'b1;
            MODE_INCLUDE:          s1_keep_in = (req_data.corner_count != '0);
            default:               s1_keep_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_keep_ff <= s1_keep_in;
      s1_op_ff   <= s1_op_in;
      s1_idx_ff  <= s1_idx_in;
      minx_ff    <= minx_in;
      maxx_ff    <= maxx_in;
      miny_ff    <= miny_in;
      maxy_ff    <= maxy_in;
   end

endmodule
`default_nettype wire

[rtl/core/dbt_queue.sv]
// Short command queue between the front and the back of the tracker.
// Uses dbt_pkg for the command type.
`default_nettype none
module dbt_queue
   import dbt_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            do_push, do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      full       = (count_ff == CW'(DEPTH));
      head_valid = (count_ff != '0);
      head_data  = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/dbt_back.sv]
// Back of the dirty band tracker: walks bands for include, clears and reads
// the span store, and holds the response register. Uses dbt_pkg and dbt_ram.
`default_nettype none
module dbt_back
   import dbt_pkg::*;
#(
   parameter int unsigned BANDS = BANDS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIM_W-1:0] display_height,
   input  wire logic             q_valid,
   input  wire cmd_type          q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam int unsigned AW          = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int unsigned CW          = $clog2(BANDS + 1);
   localparam int unsigned TOP_W       = DIM_W + IDX_W;
   localparam int unsigned NUM_W       = DIM_W + 1;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** RECIP_SHIFT) + BANDS - 1) / BANDS);
   localparam int unsigned SPAN_W      = $bits(span_type);

   back_state_type   state_ff, state_in;

   // Band height: ceil(height / BANDS) by reciprocal multiply, registered.
   logic [PROD_W-1:0] bh_prod;
   logic [DIM_W-1:0]  bh_ff;

   logic [BANDS-1:0]  valid_ff, valid_in;
   logic [DIM_W-1:0]  box_left_ff, box_right_ff, box_top_ff, box_bottom_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic [TOP_W-1:0]  band_top_ff, band_top_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_hit_ff,   pend_hit_in;
   logic [AW-1:0]     pend_idx_ff;
   logic [TOP_W-1:0]  top_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   span_type          ram_wdata, ram_rdata;
   logic [SPAN_W-1:0] ram_rdata_raw;

   logic              walk_done, hit, rsp_free, in_range, rd_vbit, empty, zero;
   logic              pop_include, pop_read, load_rsp;
   logic [DIM_W-1:0]  old_left, old_right, span_left, span_right;
   logic [TOP_W-1:0]  h_ext, top_sum;
   logic [TOP_W-1:0]  bh_ext;

   dbt_ram #(
      .WIDTH (SPAN_W),
      .DEPTH (BANDS)
   ) u_span_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = span_type'(ram_rdata_raw);
   assign bh_prod   = PROD_W'(NUM_W'(display_height) + NUM_W'(BANDS - 1)) * PROD_W'(RECIP);
   assign bh_ext    = TOP_W'(bh_ff);
   assign h_ext     = TOP_W'(display_height);

   always_comb begin
      walk_done = (rd_idx_ff == CW'(BANDS)) || (band_top_ff >= TOP_W'(box_bottom_ff));
      hit       = (band_top_ff < TOP_W'(box_bottom_ff)) &&
                  ((band_top_ff + bh_ext) > TOP_W'(box_top_ff));
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_head.op)
                  MODE_INCLUDE: state_in = BK_WALK;
                  MODE_READ:    state_in = BK_READ;
                  default:      state_in = BK_IDLE;
               endcase
            end
         end
         BK_WALK: begin
            if (walk_done) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ:  state_in = BK_REPLY;
         BK_REPLY: begin
            if (rsp_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop       = 1'b0;
      pop_include = 1'b0;
      pop_read    = 1'b0;
      load_rsp    = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_idx_ff[AW-1:0];
      unique case (state_ff)
         BK_IDLE: begin
            q_pop       = q_valid;
            pop_include = q_valid && (q_head.op == MODE_INCLUDE);
            pop_read    = q_valid && (q_head.op == MODE_READ);
            if (pop_read) begin
               ram_re    = 1'b1;
               ram_raddr = q_head.band_index[AW-1:0];
            end
         end
         BK_WALK: begin
            ram_re = !walk_done;
         end
         BK_READ: begin
         end
         BK_REPLY: begin
            load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Band walk: a read is issued for one band while the previous one is merged.
   always_comb begin
      rd_idx_in     = rd_idx_ff;
      band_top_in   = band_top_ff;
      pend_valid_in = 1'b0;
      pend_hit_in   = hit;
      if (pop_include) begin
         rd_idx_in   = '0;
         band_top_in = '0;
      end else if ((state_ff == BK_WALK) && !walk_done) begin
         rd_idx_in     = rd_idx_ff + CW'(1);
         band_top_in   = band_top_ff + bh_ext;
         pend_valid_in = 1'b1;
      end
   end

   // Merge of the pending band with the box; a band never written reads as zero.
   always_comb begin
      old_left   = valid_ff[pend_idx_ff] ? ram_rdata.left  : '0;
      old_right  = valid_ff[pend_idx_ff] ? ram_rdata.right : '0;
      ram_we     = pend_valid_ff && pend_hit_ff;
      ram_waddr  = pend_idx_ff;
      ram_wdata.left  = ((old_right == '0) || (box_left_ff < old_left)) ? box_left_ff : old_left;
      ram_wdata.right = (box_right_ff > old_right) ? box_right_ff : old_right;
      valid_in   = valid_ff;
      if ((state_ff == BK_IDLE) && q_valid && (q_head.op == MODE_CLEAR)) begin
         valid_in = '0;
      end else if (ram_we) begin
         valid_in[pend_idx_ff] = 1'b1;
      end
   end

   // Read reply.
   always_comb begin
      in_range   = (IDX_W + 1)'(idx_ff) < (IDX_W + 1)'(BANDS);
      rd_vbit    = in_range && valid_ff[idx_ff[AW-1:0]];
      span_left  = rd_vbit ? ram_rdata.left  : '0;
      span_right = rd_vbit ? ram_rdata.right : '0;
      empty      = span_right <= span_left;
      zero       = !in_range || empty || (top_ff >= h_ext);
      top_sum    = top_ff + bh_ext;
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         if (zero) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in.rect_left   = span_left;
            rsp_data_in.rect_top    = top_ff[DIM_W-1:0];
            rsp_data_in.rect_width  = span_right - span_left;
            rsp_data_in.rect_height = (top_sum > h_ext) ? DIM_W'(h_ext - top_ff) : bh_ff;
         end
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bh_ff       <= bh_prod[RECIP_SHIFT +: DIM_W];
      rd_idx_ff   <= rd_idx_in;
      band_top_ff <= band_top_in;
      pend_hit_ff <= pend_hit_in;
      pend_idx_ff <= rd_idx_ff[AW-1:0];
      rsp_data_ff <= rsp_data_in;
      if (pop_include) begin
         box_left_ff   <= q_head.left;
         box_right_ff  <= q_head.right;
         box_top_ff    <= q_head.top;
         box_bottom_ff <= q_head.bottom;
      end
      if (pop_read) begin
         idx_ff <= q_head.band_index;
      end
      top_ff <= TOP_W'(idx_ff) * bh_ext;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/core/dirty_band_tracker.sv]
// Top level of the dirty band tracker: configuration registers and the
// front, queue and back. Uses dbt_pkg, dbt_front, dbt_queue and dbt_back.
//
//   Channel   Direction  Handshake           Payload
//   req_*     in         req_valid/req_stall req_data  (req_type)
//   rsp_*     out        rsp_valid/rsp_stall rsp_data  (rsp_type)
//   csr_*     in         csr_we              csr_index, csr_wdata
//
// A request is registered in the front stage and pushed into the queue, and an
// idle back takes it from the queue head in the following cycle. In the back,
// a clear is done as it is taken, a read passes through the read and reply
// states before its response is presented from the response register, and an
// include walks the bands from band zero through the last band the box touches,
// reading one band while merging the previous; the band walk over the span RAM
// sets the include time.
// Reset is synchronous and clears every band span through its valid bit at once.
// Each side stalls on its own: the queue and the response register part them.
`default_nettype none
module dirty_band_tracker
   import dbt_pkg::*;
#(
   parameter int unsigned BANDS       = BANDS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   // Display size registers, to be written only while the block is idle; the block itself does not enforce this.
   logic [DIM_W-1:0] display_width_ff,  display_width_in;
   logic [DIM_W-1:0] display_height_ff, display_height_in;

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_entry, q_head;

   always_comb begin
      display_width_in  = display_width_ff;
      display_height_in = display_height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  display_width_in  = csr_wdata;
            CSR_HEIGHT: display_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_width_ff  <= WIDTH_RESET;
         display_height_ff <= HEIGHT_RESET;
      end else begin
         display_width_ff  <= display_width_in;
         display_height_ff <= display_height_in;
      end
   end

   // The front forms the clamped box and drops requests that change nothing.
   dbt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .display_width  (display_width_ff),
      .display_height (display_height_ff),
      .q_push         (q_push),
      .q_entry        (q_entry),
      .q_full         (q_full)
   );

   dbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // The back owns the span store and the response register.
   dbt_back #(
      .BANDS (BANDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .display_height (display_height_ff),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the dirty band tracker: drives requests and
// configuration writes, predicts every band rectangle and checks the responses.
// Depends on dbt_pkg and on the dirty_band_tracker RTL only.
module tb_top;
   import dbt_pkg::*;

   // The block is built with its default band count; the predictor follows it.
   localparam int BAND_COUNT = BANDS_DEF;
   // Cycles allowed after the last response for every request still held in
   // the front stage, the queue and the back to finish, each at worst a full
   // band walk, with margin.
   localparam int SETTLE_CYCLES = (QUEUE_DEF + 2) * (BAND_COUNT + 4) + 16;
   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT = 3000;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   dirty_band_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predicted block state: the configured display size and one span per
   // band. A band counts as empty while its right edge is not past its left.
   // ---------------------------------------------------------------------
   int               disp_width  = 480;
   int               disp_height = 480;
   logic [DIM_W-1:0] span_left  [BAND_COUNT];
   logic [DIM_W-1:0] span_right [BAND_COUNT];

   req_type request_q[$];     // requests waiting for the driver
   rsp_type band_rect_q[$];   // rectangles that reads have yet to return
   int      err_count = 0;

   // Idle pacing, in percent per opportunity, set per phase.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   initial begin
      for (int i = 0; i < BAND_COUNT; i++) begin
         span_left[i]  = '0;
         span_right[i] = '0;
      end
   end

   // A padded Q.4 coordinate becomes a whole pixel: negative values go to
   // zero, the fraction is dropped and the result is limited to the display.
   function automatic int to_pixel(int q, int limit);
      if (q <= 0) begin
         return 0;
      end
      return ((q >>> FRAC_BITS) > limit) ? limit : (q >>> FRAC_BITS);
   endfunction

   // Bounding box of the valid corners, padded and clamped, merged into every
   // band it touches. Counts above four use all four corners.
   function automatic void merge_box(req_type r);
      int xs[4];
      int ys[4];
      int n;
      int min_x, max_x, min_y, max_y;
      int left, right, top, bottom;
      int band_h, first, last;
      xs = '{r.corner_x0, r.corner_x1, r.corner_x2, r.corner_x3};
      ys = '{r.corner_y0, r.corner_y1, r.corner_y2, r.corner_y3};
      n = r.corner_count;
      if (n == 0) begin
         return;
      end
      if (n > MAX_CORNERS) begin
         n = MAX_CORNERS;
      end
      min_x = xs[0];
      max_x = xs[0];
      min_y = ys[0];
      max_y = ys[0];
      for (int i = 1; i < n; i++) begin
         if (xs[i] < min_x) min_x = xs[i];
         if (xs[i] > max_x) max_x = xs[i];
         if (ys[i] < min_y) min_y = ys[i];
         if (ys[i] > max_y) max_y = ys[i];
      end
      left   = to_pixel(min_x - PAD_LOW_Q, disp_width);
      right  = to_pixel(max_x + PAD_HIGH_Q, disp_width);
      top    = to_pixel(min_y - PAD_LOW_Q, disp_height);
      bottom = to_pixel(max_y + PAD_HIGH_Q, disp_height);
      if (right <= left || bottom <= top) begin
         return;
      end
      band_h = (disp_height + BAND_COUNT - 1) / BAND_COUNT;
      if (band_h == 0) begin
         return;
      end
      first = top / band_h;
      last  = (bottom - 1) / band_h;
      for (int i = first; i <= last && i < BAND_COUNT; i++) begin
         // An untouched band takes the new left edge as it is.
         if (span_right[i] == 0 || left < span_left[i]) begin
            span_left[i] = DIM_W'(left);
         end
         if (right > span_right[i]) begin
            span_right[i] = DIM_W'(right);
         end
      end
   endfunction

   // Rectangle of one band; zeros for an empty band, an index past the last
   // band, or a band that starts at or below the display bottom.
   function automatic rsp_type band_rect(int idx);
      rsp_type rect;
      int      band_h, top, rows;
      rect = '0;
      if (idx >= BAND_COUNT) begin
         return rect;
      end
      if (span_right[idx] <= span_left[idx]) begin
         return rect;
      end
      band_h = (disp_height + BAND_COUNT - 1) / BAND_COUNT;
      top = idx * band_h;
      if (top >= disp_height) begin
         return rect;
      end
      rows = (top + band_h > disp_height) ? disp_height - top : band_h;
      rect.rect_left   = span_left[idx];
      rect.rect_top    = DIM_W'(top);
      rect.rect_width  = span_right[idx] - span_left[idx];
      rect.rect_height = DIM_W'(rows);
      return rect;
   endfunction

   // Applies one accepted request to the predicted state. Only a read
   // produces a response; the unused mode changes nothing.
   function automatic void track_request(req_type r);
      case (r.mode)
         MODE_CLEAR: begin
            for (int i = 0; i < BAND_COUNT; i++) begin
               span_left[i]  = '0;
               span_right[i] = '0;
            end
         end
         MODE_INCLUDE: begin
            merge_box(r);
         end
         MODE_READ: begin
            band_rect_q.push_back(band_rect(r.band_index));
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders.
   // ---------------------------------------------------------------------
   function automatic logic signed [COORD_W-1:0] sat16(int v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return COORD_W'(v);
   endfunction

   // Every request starts from random bits so that fields the mode ignores
   // still toggle.
   function automatic req_type noise_request();
      logic [159:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic req_type read_request(int idx);
      req_type r;
      r = noise_request();
      r.mode = MODE_READ;
      r.band_index = IDX_W'(idx);
      return r;
   endfunction

   // Include with corners given in Q.4.
   function automatic req_type include_request(int count, int x0, int y0, int x1, int y1,
                                               int x2, int y2, int x3, int y3);
      req_type r;
      r = noise_request();
      r.mode = MODE_INCLUDE;
      r.corner_count = COUNT_W'(count);
      r.corner_x0 = sat16(x0);
      r.corner_y0 = sat16(y0);
      r.corner_x1 = sat16(x1);
      r.corner_y1 = sat16(y1);
      r.corner_x2 = sat16(x2);
      r.corner_y2 = sat16(y2);
      r.corner_x3 = sat16(x3);
      r.corner_y3 = sat16(y3);
      return r;
   endfunction

   function automatic req_type clear_request();
      req_type r;
      r = noise_request();
      r.mode = MODE_CLEAR;
      return r;
   endfunction

   // Mostly a point a little around the display, sometimes any 16-bit value.
   function automatic int random_coord(int dim);
      if ($urandom_range(0, 9) < 8) begin
         return int'($urandom_range(0, (dim + 8) * 16)) - 80;
      end
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int jitter(int spread);
      return int'($urandom_range(0, spread)) - spread / 2;
   endfunction

   // Random traffic: mostly well-formed includes and reads at the current
   // display size, with clears, the unused mode and raw noise mixed in.
   function automatic req_type random_request();
      req_type r;
      int      pick, bx, by, spread;
      r = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.mode = MODE_CLEAR;
      end else if (pick < 5) begin
         r.mode = mode_type'(2'd3);
      end else if (pick < 62) begin
         r.mode = MODE_INCLUDE;
         if ($urandom_range(0, 9) != 0) begin
            r.corner_count = COUNT_W'($urandom_range(1, MAX_CORNERS));
         end
         // One include in six keeps its raw corners.
         if ($urandom_range(0, 5) != 0) begin
            bx = random_coord(disp_width);
            by = random_coord(disp_height);
            spread = ($urandom_range(0, 3) == 0) ? (disp_width + disp_height) * 8
                                                 : int'($urandom_range(16, 16 * 48));
            r.corner_x0 = sat16(bx);
            r.corner_y0 = sat16(by);
            r.corner_x1 = sat16(bx + jitter(spread));
            r.corner_y1 = sat16(by + jitter(spread));
            r.corner_x2 = sat16(bx + jitter(spread));
            r.corner_y2 = sat16(by + jitter(spread));
            r.corner_x3 = sat16(bx + jitter(spread));
            r.corner_y3 = sat16(by + jitter(spread));
         end
      end else begin
         r.mode = MODE_READ;
         if ($urandom_range(0, 4) != 0) begin
            r.band_index = IDX_W'($urandom_range(0, BAND_COUNT - 1));
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. A new request is presented only when the channel is
   // empty or the current one has just been taken, so the payload holds
   // still while stalled. Idle bursts are inserted at random between
   // requests.
   // ---------------------------------------------------------------------
   int req_gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_request(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (int'($urandom_range(0, 99)) < req_idle_pct) begin
               req_gap_left = $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_data  <= request_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and stall generator. Each accepted rectangle is
   // checked field by field against the oldest predicted one.
   // ---------------------------------------------------------------------
   int rsp_stall_left = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (band_rect_q.size() == 0) begin
               $error("response with no read outstanding: %p", rsp_data);
               err_count++;
            end else begin
               want = band_rect_q.pop_front();
               if (rsp_data.rect_left !== want.rect_left) begin
                  $error("rect_left: expected %0d, got %0d", want.rect_left, rsp_data.rect_left);
                  err_count++;
               end
               if (rsp_data.rect_top !== want.rect_top) begin
                  $error("rect_top: expected %0d, got %0d", want.rect_top, rsp_data.rect_top);
                  err_count++;
               end
               if (rsp_data.rect_width !== want.rect_width) begin
                  $error("rect_width: expected %0d, got %0d",
                         want.rect_width, rsp_data.rect_width);
                  err_count++;
               end
               if (rsp_data.rect_height !== want.rect_height) begin
                  $error("rect_height: expected %0d, got %0d",
                         want.rect_height, rsp_data.rect_height);
                  err_count++;
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else if (int'($urandom_range(0, 99)) < rsp_idle_pct) begin
            rsp_stall_left = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any handshake or register write restarts the count.
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing.
   // ---------------------------------------------------------------------

   // Waits until every request has been taken and every read answered, then
   // lets any trailing includes finish their band walks. The queues are
   // looked at on the falling edge, away from the clocked processes.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (request_q.size() != 0 || req_valid || band_rect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle, so the predictor
   // can take the new value at once.
   task automatic write_csr(csr_index_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(value);
      if (idx == CSR_WIDTH) begin
         disp_width = value & 12'hFFF;
      end else begin
         disp_height = value & 12'hFFF;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One configuration phase. Halfway through, the sender holds back until
   // every read of the first half has been answered.
   task automatic run_phase(int width, int height, int count, bit calm);
      wait_drained();
      write_csr(CSR_WIDTH, width);
      write_csr(CSR_HEIGHT, height);
      @(negedge clock);
      req_idle_pct = calm ? 0 : $urandom_range(0, 30);
      rsp_idle_pct = calm ? 0 : $urandom_range(0, 30);
      for (int i = 0; i < count / 2; i++) begin
         request_q.push_back(random_request());
      end
      wait_drained();
      @(negedge clock);
      for (int i = count / 2; i < count; i++) begin
         request_q.push_back(random_request());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of 480 by 480 (bands of 30 rows).
      @(negedge clock);
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      // A band that was never touched reads as zeros.
      request_q.push_back(read_request(0));
      // Zero corners leave every band alone.
      request_q.push_back(include_request(0, 1600, 1600, 1600, 1600, 0, 0, 0, 0));
      request_q.push_back(read_request(0));
      // A single corner at the origin pads to a 4 pixel box in band zero.
      request_q.push_back(include_request(1, 0, 0, 0, 0, 0, 0, 0, 0));
      request_q.push_back(read_request(0));
      // Coordinate extremes clamp to the whole display and touch every band.
      request_q.push_back(include_request(4, -32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
      request_q.push_back(read_request(15));
      request_q.push_back(clear_request());
      // A count above four uses all four corners.
      request_q.push_back(include_request(7, 1600, 1600, 3200, 640, 2400, 4800, 1920, 1440));
      // Band merge: a smaller left edge wins, then a larger right edge wins.
      request_q.push_back(include_request(2, 800, 800, 960, 960, 0, 0, 0, 0));
      request_q.push_back(include_request(2, 6400, 720, 6560, 736, 0, 0, 0, 0));
      request_q.push_back(read_request(1));
      request_q.push_back(read_request(2));
      // Boxes that clamp to nothing: left of the display and right of it.
      request_q.push_back(include_request(4, -32768, 1600, -32768, 1700,
                                          -32768, 1800, -32768, 1900));
      request_q.push_back(include_request(1, 9600, 1600, 0, 0, 0, 0, 0, 0));
      // Indexes past the last band.
      request_q.push_back(read_request(BAND_COUNT));
      request_q.push_back(read_request(63));
      // The unused mode is dropped without a response.
      begin
         req_type odd;
         odd = noise_request();
         odd.mode = mode_type'(2'd3);
         request_q.push_back(odd);
      end
      request_q.push_back(read_request(10));
      request_q.push_back(read_request(11));
      // Fraction bits are truncated after padding.
      request_q.push_back(include_request(1, 175, 175, 0, 0, 0, 0, 0, 0));
      request_q.push_back(read_request(0));
      request_q.push_back(clear_request());
      request_q.push_back(read_request(1));

      // Random phases across display sizes, extremes included. Zero sizes
      // exercise the degenerate display; the last phase runs without idling.
      run_phase(4095, 4095, 180, 1'b0);
      run_phase(1, 1, 60, 1'b0);
      run_phase(0, 200, 40, 1'b0);
      run_phase(320, 0, 40, 1'b0);
      run_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 200, 1'b0);
      run_phase($urandom_range(1, 4095), $urandom_range(1, 120), 200, 1'b0);
      run_phase(480, 480, 230, 1'b1);

      wait_drained();
      if (band_rect_q.size() != 0) begin
         $error("%0d reads never answered", band_rect_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
